FILE: hdl/wcs_pkg.sv
// Package for the wash cycle sequencer: constants, phase codes, register indexes and payload types
`timescale 1ns / 1ps
package wcs_pkg;

    // Sequence constants
    localparam logic [7:0] WASH_CYCLES  = 8'd10;
    localparam logic [7:0] SETTLE_TICKS = 8'd1;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int LEVEL_W = 10;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_FILL    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_BOTTOM  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RAISE   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SETTLE1 = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LOWER   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SETTLE2 = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DRAIN   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOAP_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOAP_OFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEVEL = 3'd7;

    // Register reset values (duty is 1023 * percent / 100, truncated)
    localparam logic [TICK_W-1:0]  RST_TICKS       = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_SPIN_LEVEL  = 10'd511;
    localparam logic [LEVEL_W-1:0] RST_RAISE_LEVEL = 10'd818;
    localparam logic [LEVEL_W-1:0] RST_LOWER_LEVEL = 10'd511;

    // One tick of switch inputs
    typedef struct packed {
        logic button_held;
        logic top_switch;
        logic bottom_switch;
    } t_wcs_in;

    // Actuator and status result of one tick
    typedef struct packed {
        logic               fill_pump;
        logic               drain_pump;
        logic               soap_pump;
        logic               spin_lamp;
        logic [LEVEL_W-1:0] spin_drive;
        logic [LEVEL_W-1:0] raise_drive;
        logic [LEVEL_W-1:0] lower_drive;
        logic [PHASE_W-1:0] phase;
    } t_wcs_out;

endpackage

FILE: hdl/wcs_if.sv
// Valid/ready channel interfaces for the tick input and the result output
`timescale 1ns / 1ps
interface wcs_in_if import wcs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_wcs_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wcs_out_if import wcs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_wcs_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/wash_cycle_sequencer.sv
// Wash cycle sequencer: phase control, soap toggle generator and result register
//
//  Channel   Direction  Transaction
//  i_tick    in         one 10 ms tick: button_held, top_switch, bottom_switch
//  o_res     out        pump and lamp enables, motor duties, phase
//  i_cfg_*   in         register write: index, 16-bit data, no read-back
//
//  State and the result register load at the accepting edge, and the result is
//  offered on the next cycle. One tick is accepted every clock while the result
//  is not stalled, as the single result register allows a tick whenever the
//  register is empty or its result is taken in the same cycle.
//  Synchronous active-low reset returns the phase to idle and the registers
//  to their defaults; a stalled result holds and blocks further ticks.
`timescale 1ns / 1ps
module wash_cycle_sequencer import wcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    wcs_in_if.sink                i_tick,
    wcs_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [TICK_W-1:0]  r_fill_ticks, r_bottom_wait_ticks, r_drain_ticks;
    logic [TICK_W-1:0]  r_soap_on_ticks, r_soap_off_ticks;
    logic [LEVEL_W-1:0] r_spin_level, r_raise_level, r_lower_level;

    // Sequencer state
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TICK_W-1:0]  r_phase_timer, n_phase_timer;
    logic [7:0]         r_cycle_index, n_cycle_index;
    logic               r_spin_running, n_spin_running;
    logic               r_soap_enable, n_soap_enable;
    logic               r_soap_on_phase, n_soap_on_phase;
    logic               r_soap_alive, n_soap_alive;
    logic [TICK_W-1:0]  r_soap_timer, n_soap_timer;

    // Result register
    logic     r_out_valid;
    t_wcs_out r_out, n_out;

    logic       accept;
    logic [7:0] cycle_inc;

    // Take a tick when the result register is free or draining this cycle
    assign i_tick.ready = !r_out_valid || o_res.ready;
    assign accept       = i_tick.valid && i_tick.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;
    assign cycle_inc    = r_cycle_index + 8'd1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_ticks        <= RST_TICKS;
            r_bottom_wait_ticks <= RST_TICKS;
            r_drain_ticks       <= RST_TICKS;
            r_soap_on_ticks     <= RST_TICKS;
            r_soap_off_ticks    <= RST_TICKS;
            r_spin_level        <= RST_SPIN_LEVEL;
            r_raise_level       <= RST_RAISE_LEVEL;
            r_lower_level       <= RST_LOWER_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILL:        r_fill_ticks        <= i_cfg_data;
                CFG_BOTTOM_WAIT: r_bottom_wait_ticks <= i_cfg_data;
                CFG_DRAIN:       r_drain_ticks       <= i_cfg_data;
                CFG_SOAP_ON:     r_soap_on_ticks     <= i_cfg_data;
                CFG_SOAP_OFF:    r_soap_off_ticks    <= i_cfg_data;
                CFG_SPIN_LEVEL:  r_spin_level        <= i_cfg_data[LEVEL_W-1:0];
                CFG_RAISE_LEVEL: r_raise_level       <= i_cfg_data[LEVEL_W-1:0];
                CFG_LOWER_LEVEL: r_lower_level       <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one tick
    always_comb begin
        n_phase         = r_phase;
        n_phase_timer   = r_phase_timer;
        n_cycle_index   = r_cycle_index;
        n_spin_running  = r_spin_running;
        n_soap_enable   = r_soap_enable;
        n_soap_on_phase = r_soap_on_phase;
        n_soap_alive    = r_soap_alive;
        n_soap_timer    = r_soap_timer;

        // Advance the soap generator, using the enable as it stood before this tick
        if (r_soap_alive) begin
            if (r_soap_on_phase) begin
                if (r_soap_timer >= r_soap_on_ticks) begin
                    n_soap_on_phase = 1'b0;
                    n_soap_timer    = 16'd1;
                end else begin
                    n_soap_timer = r_soap_timer + 16'd1;
                end
            end else if (r_soap_timer >= r_soap_off_ticks) begin
                if (r_soap_enable) begin
                    n_soap_on_phase = 1'b1;
                    n_soap_timer    = 16'd1;
                end else begin
                    n_soap_alive = 1'b0;
                    n_soap_timer = 16'd0;
                end
            end else begin
                n_soap_timer = r_soap_timer + 16'd1;
            end
        end

        // Advance the phase
        unique case (r_phase)
            PH_FILL: begin
                if (r_phase_timer >= r_fill_ticks) begin
                    n_soap_alive    = 1'b1;
                    n_soap_on_phase = 1'b1;
                    n_soap_timer    = 16'd1;
                    n_cycle_index   = 8'd0;
                    n_phase_timer   = 16'd1;
                    if (!i_tick.data.button_held) begin
                        n_soap_enable  = 1'b0;
                        n_spin_running = 1'b0;
                        n_phase        = PH_DRAIN;
                    end else begin
                        n_soap_enable  = 1'b1;
                        n_spin_running = 1'b1;
                        n_phase        = PH_BOTTOM;
                    end
                end else begin
                    n_phase_timer = r_phase_timer + 16'd1;
                end
            end
            PH_BOTTOM: begin
                if (r_phase_timer >= r_bottom_wait_ticks) begin
                    n_phase       = PH_RAISE;
                    n_phase_timer = 16'd1;
                end else begin
                    n_phase_timer = r_phase_timer + 16'd1;
                end
            end
            PH_RAISE: begin
                if (i_tick.data.top_switch) begin
                    n_phase       = PH_SETTLE1;
                    n_phase_timer = 16'd1;
                end else if (!i_tick.data.button_held) begin
                    n_soap_enable  = 1'b0;
                    n_spin_running = 1'b0;
                    n_phase        = PH_DRAIN;
                    n_phase_timer  = 16'd1;
                end
            end
            PH_SETTLE1: begin
                if (r_phase_timer >= {8'd0, SETTLE_TICKS}) begin
                    n_phase       = PH_LOWER;
                    n_phase_timer = 16'd1;
                end else begin
                    n_phase_timer = r_phase_timer + 16'd1;
                end
            end
            PH_LOWER: begin
                if (i_tick.data.bottom_switch) begin
                    n_phase       = PH_SETTLE2;
                    n_phase_timer = 16'd1;
                end else if (!i_tick.data.button_held) begin
                    n_soap_enable  = 1'b0;
                    n_spin_running = 1'b0;
                    n_phase        = PH_DRAIN;
                    n_phase_timer  = 16'd1;
                end
            end
            PH_SETTLE2: begin
                if (r_phase_timer >= {8'd0, SETTLE_TICKS}) begin
                    n_cycle_index = cycle_inc;
                    n_phase_timer = 16'd1;
                    if (cycle_inc >= WASH_CYCLES) begin
                        n_phase = PH_DRAIN;
                    end else if (!i_tick.data.button_held) begin
                        n_soap_enable  = 1'b0;
                        n_spin_running = 1'b0;
                        n_phase        = PH_DRAIN;
                    end else begin
                        n_soap_enable  = 1'b1;
                        n_spin_running = 1'b1;
                        n_phase        = PH_BOTTOM;
                    end
                end else begin
                    n_phase_timer = r_phase_timer + 16'd1;
                end
            end
            PH_DRAIN: begin
                if (r_phase_timer >= r_drain_ticks) begin
                    n_soap_enable  = 1'b0;
                    n_spin_running = 1'b0;
                    n_phase        = PH_RELEASE;
                    n_phase_timer  = 16'd1;
                end else begin
                    n_phase_timer = r_phase_timer + 16'd1;
                end
            end
            PH_RELEASE: begin
                if (!i_tick.data.button_held) begin
                    n_phase       = PH_IDLE;
                    n_phase_timer = 16'd0;
                end
            end
            default: begin
                // Idle, and any code out of range
                if (i_tick.data.button_held) begin
                    n_phase       = PH_FILL;
                    n_phase_timer = 16'd1;
                end else begin
                    n_phase       = PH_IDLE;
                    n_phase_timer = 16'd0;
                end
            end
        endcase
    end

    // Build the result from the state after the tick
    always_comb begin
        n_out.fill_pump   = (n_phase == PH_FILL);
        n_out.drain_pump  = (n_phase == PH_DRAIN);
        n_out.soap_pump   = n_soap_alive && n_soap_on_phase;
        n_out.spin_lamp   = n_spin_running;
        n_out.spin_drive  = n_spin_running ? r_spin_level : '0;
        n_out.raise_drive = (n_phase == PH_RAISE) ? r_raise_level : '0;
        n_out.lower_drive = (n_phase == PH_LOWER) ? r_lower_level : '0;
        n_out.phase       = n_phase;
    end

    // Update state on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_phase_timer   <= '0;
            r_cycle_index   <= '0;
            r_spin_running  <= 1'b0;
            r_soap_enable   <= 1'b0;
            r_soap_on_phase <= 1'b0;
            r_soap_alive    <= 1'b0;
            r_soap_timer    <= '0;
        end else if (accept) begin
            r_phase         <= n_phase;
            r_phase_timer   <= n_phase_timer;
            r_cycle_index   <= n_cycle_index;
            r_spin_running  <= n_spin_running;
            r_soap_enable   <= n_soap_enable;
            r_soap_on_phase <= n_soap_on_phase;
            r_soap_alive    <= n_soap_alive;
            r_soap_timer    <= n_soap_timer;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: hdl/wcs_checker.sv
// Port-level assertions for the wash cycle sequencer, bound to the top level
`timescale 1ns / 1ps
module wcs_checker import wcs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_res_valid,
    input logic     i_res_ready,
    input t_wcs_out i_res_data
);

    // Stalled result keeps its transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    // Pumps follow their phases
    a_pump_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.fill_pump == (i_res_data.phase == PH_FILL)) &&
                        (i_res_data.drain_pump == (i_res_data.phase == PH_DRAIN)))
        else $error("pump enable disagrees with phase");

    // Lift motors only run in their phases
    a_lift_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.raise_drive == '0 || i_res_data.phase == PH_RAISE) &&
                        (i_res_data.lower_drive == '0 || i_res_data.phase == PH_LOWER))
        else $error("lift motor driven outside its phase");

    // Spin drive requires the spin lamp; lamp is off when idle
    a_spin_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.spin_drive == '0 || i_res_data.spin_lamp) &&
                        !(i_res_data.spin_lamp && i_res_data.phase == PH_IDLE))
        else $error("spin drive and lamp disagree");

endmodule

bind wash_cycle_sequencer wcs_checker u_wcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
